@@ hdl/tbdr_pkg.sv @@
// ----------------------------------------------------------------------------
// tbdr_pkg: shared types and constants
// Event codes, configuration register indexes, reset values and the status
// record passed from each button debouncer to the request logic.
// ----------------------------------------------------------------------------
package tbdr_pkg;

	typedef enum logic [1:0] {
		FUNC_POLL   = 2'd0,
		FUNC_ARM    = 2'd1,
		FUNC_DISARM = 2'd2,
		FUNC_ACK    = 2'd3
	} func_t;

	localparam logic [1:0] CFG_SETTLE_READS   = 2'd0;
	localparam logic [1:0] CFG_HOLD_TICKS     = 2'd1;
	localparam logic [1:0] CFG_COOLDOWN_TICKS = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned RUN_W      = 8;
	localparam int unsigned TICK_W     = 16;

	localparam logic [RUN_W-1:0]  RUN_MAX             = 8'd255;
	localparam logic [RUN_W-1:0]  SETTLE_READS_RST    = 8'd3;
	localparam logic [TICK_W-1:0] HOLD_TICKS_RST      = 16'd200;
	localparam logic [TICK_W-1:0] COOLDOWN_TICKS_RST  = 16'd500;

	// Level 1 on a button pin means released.
	localparam logic LEVEL_RELEASED = 1'b1;

	typedef struct packed {
		logic stable_nx;   // stable level after this reading
		logic changed;     // stable level changes with this reading
	} deb_status_t;

endpackage

@@ hdl/tbdr_debounce.sv @@
// ----------------------------------------------------------------------------
// tbdr_debounce: counter debouncer for one button
// Counts identical consecutive readings; the stable level follows the raw
// level once the run reaches the configured count.
// ----------------------------------------------------------------------------
module tbdr_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          rd,
	input  logic [tbdr_pkg::RUN_W-1:0]    settle_reads,
	output tbdr_pkg::deb_status_t         status
);

	logic                       stable_q;
	logic                       last_q;
	logic [tbdr_pkg::RUN_W-1:0] run_q;
	logic [tbdr_pkg::RUN_W-1:0] run_nx;

	// Without a reading this cycle the stable level is reported as it is.
	always_comb begin
		if (rd == last_q) begin
			run_nx = (run_q == tbdr_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
		end else begin
			run_nx = {{(tbdr_pkg::RUN_W-1){1'b0}}, 1'b1};
		end
		status.changed   = en && (run_nx >= settle_reads) && (rd != stable_q);
		status.stable_nx = status.changed ? rd : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= tbdr_pkg::LEVEL_RELEASED;
			last_q   <= tbdr_pkg::LEVEL_RELEASED;
			run_q    <= '0;
		end else if (en) begin
			stable_q <= status.stable_nx;
			last_q   <= rd;
			run_q    <= run_nx;
		end
	end

endmodule

@@ hdl/two_button_debounce_request_logic.sv @@
// ----------------------------------------------------------------------------
// two_button_debounce_request_logic: two-button debounce and request flags
// Debounces two active-low buttons per poll tick and raises upload, cancel
// and format requests; arm, disarm and acknowledge events manage the flags.
// ----------------------------------------------------------------------------
// Path: an accepted item beat is held in the input register, then its result
// beat in the result register, where back-pressure can hold it.
// Throughput: one item per cycle while result_ready is high; the state update between
// the two registers is the only loop, so back-to-back items wait only on a stall.
// Reset: arst_n clears the pipeline valids, the debouncers, counters, mode and
// flags at once, and loads the configuration registers with 3, 200 and 500.
// ----------------------------------------------------------------------------
module two_button_debounce_request_logic (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [tbdr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// item channel
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [1:0]                        func,
	input  logic                              level_a,
	input  logic                              level_b,
	input  logic                              ack_upload,
	input  logic                              ack_cancel,
	input  logic                              ack_format,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              a_pressed,
	output logic                              b_pressed,
	output logic                              upload_pending,
	output logic                              cancel_pending,
	output logic                              format_pending,
	output logic                              armed_now
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes must land only while the block is idle, so
	// they need no interlock with the pipeline; the block does not enforce this.
	// ------------------------------------------------------------------
	logic [tbdr_pkg::RUN_W-1:0]  settle_reads_q;
	logic [tbdr_pkg::TICK_W-1:0] hold_ticks_q;
	logic [tbdr_pkg::TICK_W-1:0] cooldown_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_reads_q   <= tbdr_pkg::SETTLE_READS_RST;
			hold_ticks_q     <= tbdr_pkg::HOLD_TICKS_RST;
			cooldown_ticks_q <= tbdr_pkg::COOLDOWN_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbdr_pkg::CFG_SETTLE_READS: begin
					settle_reads_q <= cfg_data[tbdr_pkg::RUN_W-1:0];
				end
				tbdr_pkg::CFG_HOLD_TICKS: begin
					hold_ticks_q <= cfg_data;
				end
				tbdr_pkg::CFG_COOLDOWN_TICKS: begin
					cooldown_ticks_q <= cfg_data;
				end
				default: begin
					// Writes to an unused index are dropped.
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control. Stage 1 is the input register, stage 2 the result
	// register. The item in stage 1 is processed and committed to the
	// state in the cycle it moves into stage 2, so each item sees the state
	// left by the one before it. Stage 1 accepts a new beat whenever it is
	// empty or is moving on in the same cycle; while a finished result waits in
	// stage 2, stage 1 can still take a beat only if it is empty.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register payload.
	tbdr_pkg::func_t func_s1;
	logic            level_a_s1;
	logic            level_b_s1;
	logic            ack_upload_s1;
	logic            ack_cancel_s1;
	logic            ack_format_s1;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			func_s1       <= tbdr_pkg::func_t'(func);
			level_a_s1    <= level_a;
			level_b_s1    <= level_b;
			ack_upload_s1 <= ack_upload;
			ack_cancel_s1 <= ack_cancel;
			ack_format_s1 <= ack_format;
		end
	end

	// ------------------------------------------------------------------
	// Debouncers. They only step on poll ticks; other events leave them
	// untouched and see their stable levels unchanged.
	// ------------------------------------------------------------------
	logic                  poll;
	tbdr_pkg::deb_status_t deb_a;
	tbdr_pkg::deb_status_t deb_b;

	assign poll = advance && (func_s1 == tbdr_pkg::FUNC_POLL);

	tbdr_debounce u_deb_a (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (poll),
		.rd           (level_a_s1),
		.settle_reads (settle_reads_q),
		.status       (deb_a)
	);

	tbdr_debounce u_deb_b (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (poll),
		.rd           (level_b_s1),
		.settle_reads (settle_reads_q),
		.status       (deb_b)
	);

	// ------------------------------------------------------------------
	// Request state and its next value.
	// ------------------------------------------------------------------
	logic [tbdr_pkg::TICK_W-1:0] hold_count_q;
	logic [tbdr_pkg::TICK_W-1:0] cooldown_left_q;
	logic                        armed_q;
	logic                        upload_q;
	logic                        cancel_q;
	logic                        format_q;

	logic [tbdr_pkg::TICK_W-1:0] hold_count_nx;
	logic [tbdr_pkg::TICK_W-1:0] hold_inc;
	logic [tbdr_pkg::TICK_W-1:0] cooldown_left_nx;
	logic                        armed_nx;
	logic                        upload_nx;
	logic                        cancel_nx;
	logic                        format_nx;

	assign hold_inc = hold_count_q + 1'b1;

	always_comb begin
		hold_count_nx    = hold_count_q;
		cooldown_left_nx = cooldown_left_q;
		armed_nx         = armed_q;
		upload_nx        = upload_q;
		cancel_nx        = cancel_q;
		format_nx        = format_q;

		unique case (func_s1)
			tbdr_pkg::FUNC_POLL: begin
				// The cooldown is decremented first; a release counts only
				// once the decremented value has reached zero.
				if (cooldown_left_q != '0) begin
					cooldown_left_nx = cooldown_left_q - 1'b1;
				end

				// A debounced release of button A raises cancel when armed,
				// otherwise upload.
				if (deb_a.changed && (deb_a.stable_nx == tbdr_pkg::LEVEL_RELEASED)
					&& (cooldown_left_nx == '0)) begin
					if (armed_q) begin
						cancel_nx = 1'b1;
					end else begin
						upload_nx = 1'b1;
					end
				end

				// Button B held for the configured number of ticks raises
				// format and restarts the count. A lowered threshold fires as
				// soon as the count reaches or passes it.
				if (deb_b.stable_nx != tbdr_pkg::LEVEL_RELEASED) begin
					if (hold_inc >= hold_ticks_q) begin
						format_nx     = 1'b1;
						hold_count_nx = '0;
					end else begin
						hold_count_nx = hold_inc;
					end
				end else begin
					hold_count_nx = '0;
				end
			end
			tbdr_pkg::FUNC_ARM: begin
				armed_nx  = 1'b1;
				cancel_nx = 1'b0;
			end
			tbdr_pkg::FUNC_DISARM: begin
				armed_nx         = 1'b0;
				cancel_nx        = 1'b0;
				upload_nx        = 1'b0;
				cooldown_left_nx = cooldown_ticks_q;
			end
			tbdr_pkg::FUNC_ACK: begin
				if (ack_upload_s1) begin
					upload_nx = 1'b0;
				end
				if (ack_cancel_s1) begin
					cancel_nx = 1'b0;
				end
				if (ack_format_s1) begin
					format_nx = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q    <= '0;
			cooldown_left_q <= '0;
			armed_q         <= 1'b0;
			upload_q        <= 1'b0;
			cancel_q        <= 1'b0;
			format_q        <= 1'b0;
		end else if (advance) begin
			hold_count_q    <= hold_count_nx;
			cooldown_left_q <= cooldown_left_nx;
			armed_q         <= armed_nx;
			upload_q        <= upload_nx;
			cancel_q        <= cancel_nx;
			format_q        <= format_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register. The debounced levels are inverted so that 1 means
	// pressed on the result beat.
	// ------------------------------------------------------------------
	logic a_pressed_s2;
	logic b_pressed_s2;
	logic upload_s2;
	logic cancel_s2;
	logic format_s2;
	logic armed_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			a_pressed_s2 <= ~deb_a.stable_nx;
			b_pressed_s2 <= ~deb_b.stable_nx;
			upload_s2    <= upload_nx;
			cancel_s2    <= cancel_nx;
			format_s2    <= format_nx;
			armed_s2     <= armed_nx;
		end
	end

	assign result_valid   = valid_s2;
	assign a_pressed      = a_pressed_s2;
	assign b_pressed      = b_pressed_s2;
	assign upload_pending = upload_s2;
	assign cancel_pending = cancel_s2;
	assign format_pending = format_s2;
	assign armed_now      = armed_s2;

endmodule

@@ hdl/tbdr_checker.sv @@
// ----------------------------------------------------------------------------
// tbdr_checker: port-level checks for the debounce request block
// Watches the top-level ports and flags handshake and flag-consistency slips.
// ----------------------------------------------------------------------------
module tbdr_checker (
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic a_pressed,
	input logic b_pressed,
	input logic upload_pending,
	input logic cancel_pending,
	input logic format_pending,
	input logic armed_now
);

	// A stalled result beat stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(a_pressed) && $stable(b_pressed)
			&& $stable(upload_pending) && $stable(cancel_pending)
			&& $stable(format_pending) && $stable(armed_now))
		else $error("result payload changed while stalled");

	// Cancel is raised only while armed, and leaving armed mode clears it.
	a_cancel_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cancel_pending |-> armed_now)
		else $error("cancel request shown while not armed");

	// With no result waiting the pipeline always has room for a new beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item side stalled with an empty result register");

endmodule

bind two_button_debounce_request_logic tbdr_checker u_tbdr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.a_pressed      (a_pressed),
	.b_pressed      (b_pressed),
	.upload_pending (upload_pending),
	.cancel_pending (cancel_pending),
	.format_pending (format_pending),
	.armed_now      (armed_now)
);
